[hw/rtl/tas_pkg.sv]
`timescale 1ns / 1ps
package tas_pkg;
	localparam int NewDepth     = 16;
	localparam int BlockedDepth = 16;
	localparam int Programs     = 8;
	localparam int ReadyDepth   = 8;
	localparam int NewAw        = $clog2(NewDepth);
	localparam int BlkAw        = $clog2(BlockedDepth);
	localparam int ProgW        = 3;
	localparam int RdyAw        = $clog2(ReadyDepth);
	localparam int RdyMemAw     = $clog2(Programs * ReadyDepth);
	localparam int PairW        = 19;

	localparam logic [1:0] ModeCreate   = 2'd0;
	localparam logic [1:0] ModeSchedule = 2'd1;
	localparam logic [1:0] ModeWait     = 2'd2;
	localparam logic [1:0] ModeSignal   = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture request
		logic create;      // append request pair to new list
		logic scan_start;  // start search at index 0
		logic scan_step;   // advance search index
		logic move_step;   // shift one entry toward the head of a list
		logic move_start;  // begin gap close at the search index
		logic to_blocked;  // wait: copy found new entry to blocked tail
		logic to_new;      // signal: copy found blocked entry to new tail
		logic admit_one;   // move new head into its ready queue
		logic pop_start;   // begin ready-queue pop
		logic pop_step;    // shift ready queue one slot
		logic pop_finish;  // commit pop and produce the reply
		logic err_finish;  // produce an error reply
		logic head_rd;     // read new head / ready entry
	} tas_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] mode;
		logic       match;      // searched entry equals key
		logic       scan_end;   // search index reached count
		logic       move_end;   // gap close finished
		logic       new_full;
		logic       blk_full;
		logic       can_admit;  // count below limit, new nonempty, target not full
		logic       rdy_nonempty;
		logic       pop_end;
	} tas_sts_t;
endpackage

[hw/rtl/thread_admission_scheduler_core.sv]
`timescale 1ns / 1ps
// Thread admission scheduler. One request word is handled at a time and a new
// one is taken as soon as the controller is idle. A wait or signal compares
// list entries one by one and, on a match, shifts the entries behind it to
// close the gap. Schedule-next admits threads from the new-list head into
// their ready queues while allowed, then pops the ready queue (or gives an
// error reply). The list memories are compacted one entry per cycle. Only
// schedule-next returns a reply word; its last step waits while an earlier
// reply word is still held. admit_limit is written through the cfg channel.
module thread_admission_scheduler_core
	import tas_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // mode[1:0], thread_id[17:2], program_slot[20:18]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // status[0], chosen_thread[16:1], to_program[19:17]
	input  logic        cfg_tvalid,
	output logic        cfg_tready,
	input  logic [7:0]  cfg_tdata  // admit_limit[3:0]
);
	tas_cmd_t    cmd;
	tas_sts_t    sts;
	logic        res_valid;
	logic [19:0] res_data;
	logic        busy;

	assign cfg_tready = 1'b1;

	tas_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_busy(busy), .sts(sts), .cmd(cmd)
	);

	tas_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_mode(s_tdata[1:0]), .in_thread(s_tdata[17:2]), .in_prog(s_tdata[20:18]),
		.cfg_tvalid(cfg_tvalid), .cfg_tdata(cfg_tdata[3:0]),
		.res_valid(res_valid), .res_data(res_data)
	);

	tas_out u_out (
		.clk(clk), .arst_n(arst_n), .res_valid(res_valid), .res_data(res_data),
		.busy(busy), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);
endmodule

[hw/rtl/tas_ctrl.sv]
`timescale 1ns / 1ps
module tas_ctrl
	import tas_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  logic     m_busy,
	input  tas_sts_t sts,
	output tas_cmd_t cmd
);
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_DISP  = 10'b0000000010,
		ST_ARD   = 10'b0000000100,
		ST_ADM   = 10'b0000001000,
		ST_PRD   = 10'b0000010000,
		ST_POP   = 10'b0000100000,
		ST_SRD   = 10'b0001000000,
		ST_SCAN  = 10'b0010000000,
		ST_MOVE  = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	// A new request is taken whenever the controller is idle.
	assign s_tready = (state_q == ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tready) begin
					cmd.load = 1'b1;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.mode)
					ModeCreate: begin
						cmd.create = 1'b1;
						state_d = ST_IDLE;
					end
					ModeSchedule: begin
						cmd.head_rd = 1'b1;
						state_d = ST_ARD;
					end
					default: begin
						cmd.scan_start = 1'b1;
						state_d = ST_SRD;
					end
				endcase
			end
			ST_ARD: state_d = ST_ADM;
			ST_ADM: begin
				if (sts.can_admit) begin
					cmd.admit_one = 1'b1;
					cmd.move_start = 1'b1;
					state_d = ST_MOVE;
				end else begin
					cmd.pop_start = 1'b1;
					state_d = ST_PRD;
				end
			end
			ST_PRD: state_d = ST_POP;
			ST_POP: begin
				// Hold the pop until the reply register has been emptied.
				if (m_busy) begin
					state_d = ST_POP;
				end else if (!sts.rdy_nonempty) begin
					cmd.err_finish = 1'b1;
					state_d = ST_IDLE;
				end else if (sts.pop_end) begin
					cmd.pop_finish = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.pop_step = 1'b1;
					state_d = ST_PRD;
				end
			end
			ST_SRD: state_d = ST_SCAN;
			ST_SCAN: begin
				if (sts.scan_end) begin
					state_d = ST_IDLE;
				end else if (sts.match) begin
					if ((sts.mode == ModeWait && !sts.blk_full) ||
					    (sts.mode == ModeSignal && !sts.new_full)) begin
						cmd.to_blocked = (sts.mode == ModeWait);
						cmd.to_new = (sts.mode == ModeSignal);
						cmd.move_start = 1'b1;
						state_d = ST_MOVE;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					cmd.scan_step = 1'b1;
					state_d = ST_SRD;
				end
			end
			ST_MOVE: begin
				if (sts.move_end) begin
					state_d = ST_OUT;
				end else begin
					cmd.move_step = 1'b1;
				end
			end
			ST_OUT: begin
				// After admission gap close, try the next head.
				if (sts.mode == ModeSchedule) begin
					cmd.head_rd = 1'b1;
					state_d = ST_ARD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

[hw/rtl/tas_dp.sv]
`timescale 1ns / 1ps
module tas_dp
	import tas_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  tas_cmd_t    cmd,
	output tas_sts_t    sts,
	input  logic [1:0]  in_mode,
	input  logic [15:0] in_thread,
	input  logic [2:0]  in_prog,
	input  logic        cfg_tvalid,
	input  logic [3:0]  cfg_tdata,
	output logic        res_valid,
	output logic [19:0] res_data
);
	localparam int NcW = NewAw + 1;
	localparam int BcW = BlkAw + 1;
	localparam int RfW = RdyAw + 1;

	// List and queue storage.
	logic [PairW-1:0] new_mem [NewDepth];
	logic [PairW-1:0] blk_mem [BlockedDepth];
	logic [15:0]      rdy_mem [Programs * ReadyDepth];
	logic [RfW-1:0]   fill_q  [Programs];

	logic [NcW-1:0]   new_cnt_q;
	logic [BcW-1:0]   blk_cnt_q;
	logic [3:0]       adm_cnt_q;
	logic [3:0]       limit_q;
	logic [1:0]       mode_q;
	logic [PairW-1:0] key_q;
	logic             on_blk_q;   // gap close works on the blocked list
	logic [7:0]       idx_q;      // search or shift index
	logic [PairW-1:0] rd_new_q, rd_blk_q;
	logic [15:0]      rd_rdy_q;
	logic [15:0]      head_thr_q;

	logic [2:0]       kprog;
	logic             kvalid;
	logic [NewAw-1:0] nidx;
	logic [BlkAw-1:0] bidx;
	logic [RdyAw-1:0] ridx;
	logic [2:0]       hprog;
	logic [RfW-1:0]   hfill;
	logic [RfW-1:0]   kfill;
	logic [RdyMemAw-1:0] r_base;

	assign kprog  = key_q[18:16];
	assign kvalid = 32'(kprog) < Programs;
	assign nidx   = idx_q[NewAw-1:0];
	assign bidx   = idx_q[BlkAw-1:0];
	assign ridx   = idx_q[RdyAw-1:0];
	assign hprog  = rd_new_q[18:16];
	assign hfill  = fill_q[hprog];
	assign kfill  = fill_q[kprog];
	assign r_base = RdyMemAw'(kprog) * RdyMemAw'(ReadyDepth);

	// Status toward the controller.
	always_comb begin
		sts.mode = mode_q;
		sts.match = on_blk_q ? (rd_blk_q == key_q) : (rd_new_q == key_q);
		sts.scan_end = !kvalid ||
			(on_blk_q ? (9'(idx_q) >= 9'(blk_cnt_q)) : (9'(idx_q) >= 9'(new_cnt_q)));
		sts.move_end = on_blk_q ? (9'(idx_q) + 9'd1 >= 9'(blk_cnt_q))
		                        : (9'(idx_q) + 9'd1 >= 9'(new_cnt_q));
		sts.new_full = new_cnt_q == NcW'(NewDepth);
		sts.blk_full = blk_cnt_q == BcW'(BlockedDepth);
		sts.can_admit = (adm_cnt_q < limit_q) && (new_cnt_q != '0) &&
			(32'(hprog) < Programs) && (hfill < RfW'(ReadyDepth));
		sts.rdy_nonempty = kvalid && (kfill != '0);
		sts.pop_end = 9'(idx_q) + 9'd1 >= 9'(kfill);
	end

	// Storage writes and reads. The ready read fetches the slot behind the
	// index, which is the one shifted down on the next pop step.
	always_ff @(posedge clk) begin
		rd_new_q <= new_mem[nidx];
		rd_blk_q <= blk_mem[bidx];
		rd_rdy_q <= rdy_mem[r_base + RdyMemAw'(RdyAw'(idx_q + 8'd1))];
		if (cmd.create && kvalid && new_cnt_q < NcW'(NewDepth)) begin
			new_mem[new_cnt_q[NewAw-1:0]] <= key_q;
		end
		if (cmd.to_blocked) begin
			blk_mem[blk_cnt_q[BlkAw-1:0]] <= rd_new_q;
		end
		if (cmd.to_new) begin
			new_mem[new_cnt_q[NewAw-1:0]] <= rd_blk_q;
		end
		if (cmd.admit_one) begin
			rdy_mem[RdyMemAw'(hprog) * RdyMemAw'(ReadyDepth) + RdyMemAw'(hfill[RdyAw-1:0])]
				<= rd_new_q[15:0];
		end
		if (cmd.move_step) begin
			if (on_blk_q) begin
				blk_mem[bidx] <= blk_mem[BlkAw'(idx_q + 8'd1)];
			end else begin
				new_mem[nidx] <= new_mem[NewAw'(idx_q + 8'd1)];
			end
		end
		if (cmd.pop_step) begin
			rdy_mem[r_base + RdyMemAw'(ridx)] <= rd_rdy_q;
		end
		if (cmd.pop_start) begin
			head_thr_q <= rdy_mem[r_base];
		end
		if (cmd.load) begin
			key_q <= {in_prog, in_thread};
		end
	end

	// Control state: counts, indexes, reply register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_cnt_q <= '0;
			blk_cnt_q <= '0;
			adm_cnt_q <= '0;
			limit_q   <= 4'd3;
			mode_q    <= ModeCreate;
			on_blk_q  <= 1'b0;
			idx_q     <= '0;
			res_valid <= 1'b0;
			res_data  <= '0;
			for (int p = 0; p < Programs; p++) begin
				fill_q[p] <= '0;
			end
		end else begin
			if (cfg_tvalid) begin
				limit_q <= cfg_tdata;
			end
			if (cmd.load) begin
				mode_q <= in_mode;
				on_blk_q <= (in_mode == ModeSignal);
			end
			if (cmd.create && kvalid && new_cnt_q < NcW'(NewDepth)) begin
				new_cnt_q <= new_cnt_q + NcW'(1);
			end
			if (cmd.scan_start || cmd.head_rd) begin
				idx_q <= '0;
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + 8'd1;
			end
			if (cmd.admit_one) begin
				on_blk_q <= 1'b0;
				fill_q[hprog] <= hfill + RfW'(1);
				adm_cnt_q <= adm_cnt_q + 4'd1;
			end
			if (cmd.to_blocked) begin
				blk_cnt_q <= blk_cnt_q + BcW'(1);
			end
			if (cmd.to_new) begin
				new_cnt_q <= new_cnt_q + NcW'(1);
			end
			// Gap close: shift then drop the tail of the source list.
			if (cmd.move_step) begin
				idx_q <= idx_q + 8'd1;
				if (on_blk_q ? (9'(idx_q) + 9'd2 >= 9'(blk_cnt_q))
				             : (9'(idx_q) + 9'd2 >= 9'(new_cnt_q))) begin
					if (on_blk_q) begin
						blk_cnt_q <= blk_cnt_q - BcW'(1);
					end else begin
						new_cnt_q <= new_cnt_q - NcW'(1);
					end
				end
			end
			if ((cmd.move_start) && (on_blk_q ? (blk_cnt_q <= BcW'(1) || 9'(idx_q) + 9'd1 >= 9'(blk_cnt_q))
			                                   : (9'(idx_q) + 9'd1 >= 9'(new_cnt_q)))) begin
				if (cmd.to_new || (on_blk_q && !cmd.admit_one)) begin
					blk_cnt_q <= blk_cnt_q - BcW'(1);
				end else begin
					new_cnt_q <= new_cnt_q - NcW'(1) + NcW'(cmd.to_new);
				end
			end
			if (cmd.pop_start) begin
				idx_q <= '0;
			end
			if (cmd.pop_step) begin
				idx_q <= idx_q + 8'd1;
			end
			if (cmd.pop_finish) begin
				fill_q[kprog] <= kfill - RfW'(1);
				if (adm_cnt_q != '0) begin
					adm_cnt_q <= adm_cnt_q - 4'd1;
				end
			end
			// The reply strobe is high for one cycle per reply.
			if (cmd.pop_finish || cmd.err_finish) begin
				res_valid <= 1'b1;
				res_data <= cmd.pop_finish ? {kprog, head_thr_q, 1'b0}
				                           : {kprog, 16'd0, 1'b1};
			end else begin
				res_valid <= 1'b0;
			end
		end
	end
endmodule

[hw/rtl/tas_out.sv]
`timescale 1ns / 1ps
module tas_out
	import tas_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        res_valid,
	input  logic [19:0] res_data,
	output logic        busy,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata
);
	logic        vld_q;
	logic [19:0] data_q;

	// Hold a reply word until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			if (res_valid) begin
				vld_q <= 1'b1;
			end else if (vld_q && m_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			data_q <= res_data;
		end
	end

	assign busy     = vld_q;
	assign m_tvalid = vld_q;
	assign m_tdata  = {4'd0, data_q};
endmodule
